// ----- src/ptgs_pkg.sv -----
// ============================================================================
// ptgs_pkg
// Types and constants shared by the per-tag gap statistics block.
// ============================================================================
package ptgs_pkg;

    localparam int NUM_COUNTERS = 10;
    localparam int CIDX_W       = 4;
    localparam int TIME_W       = 48;
    localparam int FRAME_W      = 32;
    localparam int TAG_W        = 10;
    localparam int VALUE_W      = 32;

    // Counter slots
    localparam logic [CIDX_W-1:0] CNT_TOTAL = 4'd0;
    localparam logic [CIDX_W-1:0] CNT_MULTI = 4'd1;
    localparam logic [CIDX_W-1:0] CNT_LAST  = 4'd9;

    // Gap class bounds in microseconds
    localparam logic [TIME_W-1:0] GAP_HALF_S = 48'd500000;
    localparam logic [TIME_W-1:0] GAP_1S     = 48'd1000000;
    localparam logic [TIME_W-1:0] GAP_10S    = 48'd10000000;
    localparam logic [TIME_W-1:0] GAP_1M     = 48'd60000000;
    localparam logic [TIME_W-1:0] GAP_10M    = 48'd600000000;
    localparam logic [TIME_W-1:0] GAP_1H     = 48'd3600000000;
    localparam logic [TIME_W-1:0] GAP_10H    = 48'd36000000000;

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_DETECT = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NEW     = 3'd0,
        EV_REPEAT  = 3'd1,
        EV_AGAIN   = 3'd2,
        EV_READ    = 3'd3,
        EV_FINISH  = 3'd4,
        EV_UNKNOWN = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READOUT,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_FIN_DONE
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [FRAME_W-1:0] frame_number;
        logic [TIME_W-1:0]  frame_time_us;
        logic [TAG_W-1:0]   tag_id;
    } t_in_req;

    typedef struct packed {
        logic [TAG_W-1:0]   tag_id_out;
        t_kind              event_kind;
        logic [3:0]         gap_bin;
        logic [CIDX_W-1:0]  counter_index;
        logic [VALUE_W-1:0] counter_value;
        logic [TIME_W-1:0]  first_seen_us;
        logic [TIME_W-1:0]  last_seen_us;
        logic               last;
    } t_out_req;

    // Class 1..8 of the gap from earlier to later, 0 when negative
    function automatic logic [3:0] gap_class(logic [TIME_W-1:0] earlier,
                                             logic [TIME_W-1:0] later);
        logic [TIME_W-1:0] g;
        g = later - earlier;
        if (later < earlier)     return 4'd0;
        else if (g < GAP_HALF_S) return 4'd1;
        else if (g < GAP_1S)     return 4'd2;
        else if (g < GAP_10S)    return 4'd3;
        else if (g < GAP_1M)     return 4'd4;
        else if (g < GAP_10M)    return 4'd5;
        else if (g < GAP_1H)     return 4'd6;
        else if (g < GAP_10H)    return 4'd7;
        else                     return 4'd8;
    endfunction

endpackage

// ----- src/per_tag_gap_statistics.sv -----
// ============================================================================
// per_tag_gap_statistics
// Per-tag detection table: one memory row per tag, updated read-modify-write.
// ============================================================================
// Detection/read: row read, then update (write back on detection), held while
// the output is full; a read of a known tag then streams ten results, one per
// cycle while the output accepts them. Frame requests end in the idle state.
// Finish: a row read and, where due, a write-back per row, then a finish result.
// After reset a clearing pass writes every row before a request is taken.
module per_tag_gap_statistics #(
    parameter int TAG_COUNT   = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptgs_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptgs_pkg::t_out_req o_out_req
);

    localparam int TAG_AW = $clog2(TAG_COUNT);

    typedef struct packed {
        logic                                                 known;
        logic [ptgs_pkg::FRAME_W-1:0]                         last_frame;
        logic [ptgs_pkg::TIME_W-1:0]                          last_time;
        logic [ptgs_pkg::TIME_W-1:0]                          first_time;
        logic [ptgs_pkg::NUM_COUNTERS-1:0][COUNT_WIDTH-1:0]   counters;
    } t_entry;

    t_entry r_mem [TAG_COUNT];

    ptgs_pkg::t_state r_state, n_state;
    logic [TAG_AW-1:0]              r_addr, n_addr;
    logic [ptgs_pkg::FRAME_W-1:0]   r_cur_frame, n_cur_frame;
    logic [ptgs_pkg::TIME_W-1:0]    r_cur_time, n_cur_time;
    logic [ptgs_pkg::TIME_W-1:0]    r_start, n_start;
    logic                           r_started, n_started;
    ptgs_pkg::t_in_req              r_req, n_req;
    logic [ptgs_pkg::CIDX_W-1:0]    r_idx, n_idx;
    logic                           r_out_valid, n_out_valid;
    ptgs_pkg::t_out_req             r_out, n_out;
    t_entry                         r_rdata;

    logic              accept, out_free, tag_ok, in_tag_ok;
    logic              rd_en, wr_en;
    logic [TAG_AW-1:0] rd_addr, wr_addr;
    t_entry            wr_data, upd;
    logic [3:0]        bin;
    logic [63:0]       wide_val;

    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_tag_ok = 32'(i_in_req.tag_id) < TAG_COUNT;
    assign tag_ok    = 32'(r_req.tag_id) < TAG_COUNT;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptgs_pkg::ST_CLEAR: begin
                if (r_addr == TAG_AW'(TAG_COUNT - 1)) n_state = ptgs_pkg::ST_IDLE;
            end
            ptgs_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in_req.command)
                        ptgs_pkg::CMD_FRAME:  n_state = ptgs_pkg::ST_IDLE;
                        ptgs_pkg::CMD_FINISH: n_state = ptgs_pkg::ST_FIN_RD;
                        default:              n_state = ptgs_pkg::ST_UPDATE;
                    endcase
                end
            end
            ptgs_pkg::ST_UPDATE: begin
                if (out_free) begin
                    if (r_req.command == ptgs_pkg::CMD_READ && tag_ok && r_rdata.known)
                        n_state = ptgs_pkg::ST_READOUT;
                    else
                        n_state = ptgs_pkg::ST_IDLE;
                end
            end
            ptgs_pkg::ST_READOUT: begin
                if (out_free && r_idx == ptgs_pkg::CNT_LAST) n_state = ptgs_pkg::ST_IDLE;
            end
            ptgs_pkg::ST_FIN_RD: n_state = ptgs_pkg::ST_FIN_WR;
            ptgs_pkg::ST_FIN_WR: begin
                if (r_addr == TAG_AW'(TAG_COUNT - 1)) n_state = ptgs_pkg::ST_FIN_DONE;
                else                                  n_state = ptgs_pkg::ST_FIN_RD;
            end
            ptgs_pkg::ST_FIN_DONE: begin
                if (out_free) n_state = ptgs_pkg::ST_IDLE;
            end
            default: n_state = ptgs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_addr      = r_addr;
        n_cur_frame = r_cur_frame;
        n_cur_time  = r_cur_time;
        n_start     = r_start;
        n_started   = r_started;
        n_req       = r_req;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = TAG_AW'(i_in_req.tag_id);
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_data     = '0;
        upd         = r_rdata;
        bin         = 4'd0;
        wide_val    = 64'(r_rdata.counters[r_idx]);
        o_in_ready  = 1'b0;

        case (r_state)
            ptgs_pkg::ST_CLEAR: begin
                wr_en  = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ptgs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_addr     = '0;
                if (accept) begin
                    n_req = i_in_req;
                    rd_en = in_tag_ok;
                    if (i_in_req.command == ptgs_pkg::CMD_FRAME) begin
                        n_cur_frame = i_in_req.frame_number;
                        n_cur_time  = i_in_req.frame_time_us;
                        if (!r_started) begin
                            n_started = 1'b1;
                            n_start   = i_in_req.frame_time_us;
                        end
                    end
                end
            end
            ptgs_pkg::ST_UPDATE: begin
                n_idx = '0;
                if (!r_rdata.known) begin
                    upd.counters = '0;
                    upd.counters[ptgs_pkg::CNT_TOTAL] = COUNT_WIDTH'(1);
                    upd.first_time = r_cur_time;
                    if (r_cur_time > r_start) begin
                        bin = ptgs_pkg::gap_class(r_start, r_cur_time);
                        upd.counters[bin + 4'd1] = COUNT_WIDTH'(1);
                    end
                end else if (r_rdata.last_frame == r_cur_frame) begin
                    if (r_rdata.counters[ptgs_pkg::CNT_MULTI] != '1)
                        upd.counters[ptgs_pkg::CNT_MULTI] =
                            r_rdata.counters[ptgs_pkg::CNT_MULTI] + 1'b1;
                end else begin
                    if (r_rdata.counters[ptgs_pkg::CNT_TOTAL] != '1)
                        upd.counters[ptgs_pkg::CNT_TOTAL] =
                            r_rdata.counters[ptgs_pkg::CNT_TOTAL] + 1'b1;
                    if ({1'b0, r_rdata.last_frame} + 33'd1 < {1'b0, r_cur_frame}) begin
                        bin = ptgs_pkg::gap_class(r_rdata.last_time, r_cur_time);
                        if (bin != 4'd0 && r_rdata.counters[bin + 4'd1] != '1)
                            upd.counters[bin + 4'd1] = r_rdata.counters[bin + 4'd1] + 1'b1;
                    end
                end
                upd.known      = 1'b1;
                upd.last_frame = r_cur_frame;
                upd.last_time  = r_cur_time;

                if (out_free) begin
                    n_out            = '0;
                    n_out.tag_id_out = r_req.tag_id;
                    n_out.last       = 1'b1;
                    if (!tag_ok || (r_req.command == ptgs_pkg::CMD_READ && !r_rdata.known)) begin
                        n_out.event_kind = ptgs_pkg::EV_UNKNOWN;
                        n_out_valid      = 1'b1;
                    end else if (r_req.command == ptgs_pkg::CMD_DETECT) begin
                        wr_en   = 1'b1;
                        wr_addr = TAG_AW'(r_req.tag_id);
                        wr_data = upd;
                        if (!r_rdata.known)
                            n_out.event_kind = ptgs_pkg::EV_NEW;
                        else if (r_rdata.last_frame == r_cur_frame)
                            n_out.event_kind = ptgs_pkg::EV_REPEAT;
                        else
                            n_out.event_kind = ptgs_pkg::EV_AGAIN;
                        n_out.gap_bin       = bin;
                        n_out.first_seen_us = upd.first_time;
                        n_out.last_seen_us  = r_cur_time;
                        n_out_valid         = 1'b1;
                    end
                end
            end
            ptgs_pkg::ST_READOUT: begin
                if (out_free) begin
                    n_out               = '0;
                    n_out.tag_id_out    = r_req.tag_id;
                    n_out.event_kind    = ptgs_pkg::EV_READ;
                    n_out.counter_index = r_idx;
                    n_out.counter_value = (wide_val > 64'hFFFF_FFFF) ? '1 : wide_val[31:0];
                    n_out.first_seen_us = r_rdata.first_time;
                    n_out.last_seen_us  = r_rdata.last_time;
                    n_out.last          = (r_idx == ptgs_pkg::CNT_LAST);
                    n_out_valid         = 1'b1;
                    n_idx               = r_idx + 1'b1;
                end
            end
            ptgs_pkg::ST_FIN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_addr;
            end
            ptgs_pkg::ST_FIN_WR: begin
                n_addr = r_addr + 1'b1;
                if (r_rdata.known && r_rdata.last_time < r_cur_time) begin
                    bin = ptgs_pkg::gap_class(r_rdata.last_time, r_cur_time);
                    if (r_rdata.counters[bin + 4'd1] != '1)
                        upd.counters[bin + 4'd1] = r_rdata.counters[bin + 4'd1] + 1'b1;
                    wr_en   = 1'b1;
                    wr_data = upd;
                end
            end
            ptgs_pkg::ST_FIN_DONE: begin
                if (out_free) begin
                    n_out            = '0;
                    n_out.event_kind = ptgs_pkg::EV_FINISH;
                    n_out.last       = 1'b1;
                    n_out_valid      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptgs_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_cur_frame <= '0;
            r_cur_time  <= '0;
            r_start     <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cur_frame <= n_cur_frame;
            r_cur_time  <= n_cur_time;
            r_start     <= n_start;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule
